### rtl/smi_pkg.sv
// Shared types and constants for the small matrix inverse block.
// No dependencies; every other file refers to it by scoped names.
package smi_pkg;

   localparam int A_W      = 32;              // element and result width
   localparam int COF_W    = 2 * A_W + 1;     // 2x2 minor, exact
   localparam int DET_W    = COF_W + A_W + 2; // 3x3 determinant, exact
   localparam int MAG_W    = 130;             // divider magnitude width
   localparam int QB       = A_W + 1;         // quotient bits below overflow
   localparam int N_ELEM   = 9;
   localparam int N_LANE   = N_ELEM + 1;      // nine inverse entries and the determinant
   localparam int DET_LANE = N_ELEM;
   localparam int LANE_LAT = QB + 2;          // pre-check, QB steps, rounding

   typedef logic signed [A_W-1:0] elem_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_SINGULAR  = 2'd1,
      ST_SATURATED = 2'd2
   } status_type;

   typedef struct packed {
      logic             en;
      logic             neg;
      logic [MAG_W-1:0] un;
      logic [MAG_W-1:0] ud;
   } lane_in_type;

   typedef struct packed {
      logic [A_W-1:0] value;
      logic           sat;
   } lane_out_type;

   typedef struct packed {
      logic valid;
      logic singular;
   } ctl_type;

endpackage

### rtl/smi_front.sv
// Front end: cofactors, determinant and divider operands, six stages.
// Depends on smi_pkg.
module smi_front #(
   parameter int FRAC_BITS = 16,
   parameter int MAX_SIZE  = 3
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start_valid,
   input  logic [1:0]            size,
   input  smi_pkg::elem_type     elem [smi_pkg::N_ELEM],
   output smi_pkg::lane_in_type  lane [smi_pkg::N_LANE],
   output smi_pkg::ctl_type      ctl
);

   localparam int CW = smi_pkg::COF_W;
   localparam int DW = smi_pkg::DET_W;
   localparam int MW = smi_pkg::MAG_W;

   // stage 1: capture
   logic [1:0]        n_in;
   logic              v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic [1:0]        n1_ff, n2_ff, n3_ff, n4_ff, n5_ff;
   smi_pkg::elem_type m1_ff [9];
   smi_pkg::elem_type m2_ff [9];
   smi_pkg::elem_type m3_ff [9];
   smi_pkg::elem_type m4_ff [9];

   always_comb begin
      if (size == 2'd0) begin
         n_in = 2'd1;
      end else if (size > 2'(MAX_SIZE)) begin
         n_in = 2'(MAX_SIZE);
      end else begin
         n_in = size;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         v1_ff <= start_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      n1_ff <= n_in;
      n2_ff <= n1_ff;
      n3_ff <= n2_ff;
      n4_ff <= n3_ff;
      n5_ff <= n4_ff;
      m1_ff <= elem;
      m2_ff <= m1_ff;
      m3_ff <= m2_ff;
      m4_ff <= m3_ff;
   end

   // stage 2: minor products, stage 3: cofactors
   logic signed [63:0]   pa2_ff [9];
   logic signed [63:0]   pb2_ff [9];
   logic signed [CW-1:0] cof3_ff [9];
   logic signed [CW-1:0] cof4_ff [9];

   for (genvar I = 0; I < 3; I++) begin : g_row
      for (genvar J = 0; J < 3; J++) begin : g_col
         localparam int R1 = (I + 1) % 3;
         localparam int R2 = (I + 2) % 3;
         localparam int C1 = (J + 1) % 3;
         localparam int C2 = (J + 2) % 3;
         logic signed [63:0] pa_in, pb_in;
         assign pa_in = 64'(m1_ff[3*R1+C1]) * 64'(m1_ff[3*R2+C2]);
         assign pb_in = 64'(m1_ff[3*R1+C2]) * 64'(m1_ff[3*R2+C1]);
         always_ff @(posedge clock) begin
            pa2_ff[3*I+J]  <= pa_in;
            pb2_ff[3*I+J]  <= pb_in;
            cof3_ff[3*I+J] <= CW'(pa2_ff[3*I+J]) - CW'(pb2_ff[3*I+J]);
         end
      end
   end

   // stage 4: first-row cofactor times element, split in two halves
   logic signed [CW-1:0] hp4_ff [3];
   logic signed [CW-1:0] lp4_ff [3];

   for (genvar J = 0; J < 3; J++) begin : g_part
      logic signed [32:0] ch, cl;
      assign ch = cof3_ff[J][CW-1:32];
      assign cl = {1'b0, cof3_ff[J][31:0]};
      always_ff @(posedge clock) begin
         hp4_ff[J] <= CW'(ch) * CW'(m3_ff[J]);
         lp4_ff[J] <= CW'(cl) * CW'(m3_ff[J]);
      end
   end

   always_ff @(posedge clock) begin
      cof4_ff <= cof3_ff;
   end

   // stage 5: determinant and adjugate for the size in use
   logic signed [DW-1:0] det_in;
   logic signed [DW-1:0] det5_ff;
   logic signed [CW-1:0] adj_in  [9];
   logic signed [CW-1:0] adj5_ff [9];

   always_comb begin
      logic signed [DW-1:0] det3;
      det3 = '0;
      for (int j = 0; j < 3; j++) begin
         det3 = det3 + (DW'(hp4_ff[j]) <<< 32) + DW'(lp4_ff[j]);
      end
      for (int k = 0; k < 9; k++) begin
         adj_in[k] = '0;
      end
      unique case (n4_ff)
         2'd2: begin
            det_in    = DW'(cof4_ff[8]);
            adj_in[0] = CW'(m4_ff[4]);
            adj_in[1] = -CW'(m4_ff[1]);
            adj_in[3] = -CW'(m4_ff[3]);
            adj_in[4] = CW'(m4_ff[0]);
         end
         2'd3: begin
            det_in = det3;
            for (int r = 0; r < 3; r++) begin
               for (int c = 0; c < 3; c++) begin
                  adj_in[3*r+c] = cof4_ff[3*c+r];
               end
            end
         end
         default: begin
            det_in    = DW'(m4_ff[0]);
            adj_in[0] = CW'(1);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      det5_ff <= det_in;
      adj5_ff <= adj_in;
   end

   // stage 6: signs and magnitudes for the divider lanes
   logic                 nz;
   logic [DW-1:0]        dmag;
   smi_pkg::lane_in_type lane_in [smi_pkg::N_LANE];
   smi_pkg::lane_in_type lane_ff [smi_pkg::N_LANE];
   logic                 sing6_ff;

   assign nz   = (det5_ff != '0);
   assign dmag = det5_ff[DW-1] ? DW'(-det5_ff) : DW'(det5_ff);

   for (genvar K = 0; K < 9; K++) begin : g_lane
      localparam int RI = K / 3;
      localparam int CJ = K % 3;
      logic [CW-1:0] amag;
      assign amag = adj5_ff[K][CW-1] ? CW'(-adj5_ff[K]) : CW'(adj5_ff[K]);
      always_comb begin
         lane_in[K].en  = (2'(RI) < n5_ff) && (2'(CJ) < n5_ff) && nz;
         lane_in[K].neg = adj5_ff[K][CW-1] ^ det5_ff[DW-1];
         lane_in[K].un  = MW'(amag) << (2 * FRAC_BITS);
         lane_in[K].ud  = MW'(dmag);
      end
   end

   // determinant scaling is a rounded division by a power of two
   always_comb begin
      lane_in[smi_pkg::DET_LANE].en  = nz;
      lane_in[smi_pkg::DET_LANE].neg = det5_ff[DW-1];
      lane_in[smi_pkg::DET_LANE].un  = MW'(dmag);
      unique case (n5_ff)
         2'd2:    lane_in[smi_pkg::DET_LANE].ud = MW'(1) << FRAC_BITS;
         2'd3:    lane_in[smi_pkg::DET_LANE].ud = MW'(1) << (2 * FRAC_BITS);
         default: lane_in[smi_pkg::DET_LANE].ud = MW'(1);
      endcase
   end

   always_ff @(posedge clock) begin
      lane_ff  <= lane_in;
      sing6_ff <= !nz;
   end

   assign lane         = lane_ff;
   assign ctl.valid    = v6_ff;
   assign ctl.singular = sing6_ff;

endmodule

### rtl/smi_div_lane.sv
// One divider lane: restoring division, one quotient bit per stage,
// round to nearest (ties away) and clamp to 32 bits. Depends on smi_pkg.
module smi_div_lane (
   input  logic                  clock,
   input  smi_pkg::lane_in_type  din,
   output smi_pkg::lane_out_type dout
);

   localparam int QB = smi_pkg::QB;
   localparam int MW = smi_pkg::MAG_W;
   localparam int AW = smi_pkg::A_W;

   logic [MW-1:0] rem_ff [QB+1];
   logic [MW-1:0] dv_ff  [QB+1];
   logic [QB-1:0] q_ff   [QB+1];
   logic          ovf_ff [QB+1];
   logic          en_ff  [QB+1];
   logic          neg_ff [QB+1];

   // a quotient of 2^QB or more saturates whatever the low bits are
   always_ff @(posedge clock) begin
      rem_ff[0] <= din.un;
      dv_ff[0]  <= din.ud;
      q_ff[0]   <= '0;
      ovf_ff[0] <= din.un >= (din.ud << QB);
      en_ff[0]  <= din.en;
      neg_ff[0] <= din.neg;
   end

   for (genvar S = 1; S <= QB; S++) begin : g_step
      localparam int SH = QB - S;
      logic [MW-1:0] sub;
      logic          take;
      assign sub  = dv_ff[S-1] << SH;
      assign take = rem_ff[S-1] >= sub;
      always_ff @(posedge clock) begin
         rem_ff[S] <= take ? rem_ff[S-1] - sub : rem_ff[S-1];
         q_ff[S]   <= {q_ff[S-1][QB-2:0], take};
         dv_ff[S]  <= dv_ff[S-1];
         ovf_ff[S] <= ovf_ff[S-1];
         en_ff[S]  <= en_ff[S-1];
         neg_ff[S] <= neg_ff[S-1];
      end
   end

   localparam logic [QB:0] HALF = (QB + 1)'(1) << (AW - 1);

   logic [QB:0]           qr;
   logic                  rnd;
   smi_pkg::lane_out_type out_in;
   smi_pkg::lane_out_type out_ff;

   assign rnd = (rem_ff[QB] << 1) >= dv_ff[QB];
   assign qr  = {1'b0, q_ff[QB]} + {{QB{1'b0}}, rnd};

   always_comb begin
      logic sat;
      sat = ovf_ff[QB] || (qr > HALF) || ((qr == HALF) && !neg_ff[QB]);
      if (!en_ff[QB]) begin
         out_in.value = '0;
         out_in.sat   = 1'b0;
      end else if (sat) begin
         out_in.value = neg_ff[QB] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
         out_in.sat   = 1'b1;
      end else begin
         out_in.value = neg_ff[QB] ? AW'(-qr[AW-1:0]) : qr[AW-1:0];
         out_in.sat   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign dout = out_ff;

endmodule

### rtl/smi_merge.sv
// Merge stage: collects the lane results, forms status, drives the result
// register. Depends on smi_pkg.
module smi_merge (
   input  logic                  clock,
   input  logic                  reset,
   input  smi_pkg::ctl_type      ctl,
   input  smi_pkg::lane_out_type lane [smi_pkg::N_LANE],
   output logic                  valid,
   output logic [31:0]           inv [smi_pkg::N_ELEM],
   output logic [31:0]           det,
   output smi_pkg::status_type   status
);

   logic                any_sat;
   smi_pkg::status_type status_in, status_ff;
   logic                valid_ff;
   logic [31:0]         inv_ff [smi_pkg::N_ELEM];
   logic [31:0]         det_ff;

   always_comb begin
      any_sat = 1'b0;
      for (int k = 0; k < smi_pkg::N_LANE; k++) begin
         any_sat = any_sat | lane[k].sat;
      end
      priority if (ctl.singular) begin
         status_in = smi_pkg::ST_SINGULAR;
      end else if (any_sat) begin
         status_in = smi_pkg::ST_SATURATED;
      end else begin
         status_in = smi_pkg::ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      det_ff    <= lane[smi_pkg::DET_LANE].value;
      for (int k = 0; k < smi_pkg::N_ELEM; k++) begin
         inv_ff[k] <= lane[k].value;
      end
   end

   assign valid  = valid_ff;
   assign inv    = inv_ff;
   assign det    = det_ff;
   assign status = status_ff;

endmodule

### rtl/small_matrix_inverse_top.sv
// Small matrix inverse, sizes 1 to 3, by adjugate over determinant.
// A matrix taken at one edge reaches the result strobe through six front stages,
// 35 divider-lane stages and one merge register.
// Throughput: one matrix per cycle; each of the ten divider lanes retires
// one quotient bit per stage. busy stays low and the receiver cannot stall.
// Reset clears only the valid pipeline; it takes effect at the next edge.
module small_matrix_inverse_top #(
   parameter int FRAC_BITS = 16,
   parameter int MAX_SIZE  = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_size,
   input  logic [31:0] req_a00,
   input  logic [31:0] req_a01,
   input  logic [31:0] req_a02,
   input  logic [31:0] req_a10,
   input  logic [31:0] req_a11,
   input  logic [31:0] req_a12,
   input  logic [31:0] req_a20,
   input  logic [31:0] req_a21,
   input  logic [31:0] req_a22,
   output logic        rsp_valid,
   output logic [31:0] rsp_r00,
   output logic [31:0] rsp_r01,
   output logic [31:0] rsp_r02,
   output logic [31:0] rsp_r10,
   output logic [31:0] rsp_r11,
   output logic [31:0] rsp_r12,
   output logic [31:0] rsp_r20,
   output logic [31:0] rsp_r21,
   output logic [31:0] rsp_r22,
   output logic [31:0] rsp_determinant,
   output logic [1:0]  rsp_status
);

   localparam int LAT = 6 + smi_pkg::LANE_LAT + 1;

   smi_pkg::elem_type     elem [smi_pkg::N_ELEM];
   smi_pkg::lane_in_type  lane_in  [smi_pkg::N_LANE];
   smi_pkg::lane_out_type lane_out [smi_pkg::N_LANE];
   smi_pkg::ctl_type      front_ctl;
   smi_pkg::ctl_type      ctl_ff [smi_pkg::LANE_LAT];
   smi_pkg::status_type   status;
   logic [31:0]           inv [smi_pkg::N_ELEM];

   assign busy = 1'b0;

   assign elem[0] = req_a00;
   assign elem[1] = req_a01;
   assign elem[2] = req_a02;
   assign elem[3] = req_a10;
   assign elem[4] = req_a11;
   assign elem[5] = req_a12;
   assign elem[6] = req_a20;
   assign elem[7] = req_a21;
   assign elem[8] = req_a22;

   smi_front #(
      .FRAC_BITS(FRAC_BITS),
      .MAX_SIZE (MAX_SIZE)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .start_valid(start && !busy),
      .size       (req_size),
      .elem       (elem),
      .lane       (lane_in),
      .ctl        (front_ctl)
   );

   for (genvar K = 0; K < smi_pkg::N_LANE; K++) begin : g_div
      smi_div_lane u_lane (
         .clock(clock),
         .din  (lane_in[K]),
         .dout (lane_out[K])
      );
   end

   // hold control alongside the lanes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < smi_pkg::LANE_LAT; s++) begin
            ctl_ff[s] <= '0;
         end
      end else begin
         ctl_ff[0] <= front_ctl;
         for (int s = 1; s < smi_pkg::LANE_LAT; s++) begin
            ctl_ff[s] <= ctl_ff[s-1];
         end
      end
   end

   smi_merge u_merge (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl_ff[smi_pkg::LANE_LAT-1]),
      .lane  (lane_out),
      .valid (rsp_valid),
      .inv   (inv),
      .det   (rsp_determinant),
      .status(status)
   );

   assign rsp_status = status;
   assign rsp_r00 = inv[0];
   assign rsp_r01 = inv[1];
   assign rsp_r02 = inv[2];
   assign rsp_r10 = inv[3];
   assign rsp_r11 = inv[4];
   assign rsp_r12 = inv[5];
   assign rsp_r20 = inv[6];
   assign rsp_r21 = inv[7];
   assign rsp_r22 = inv[8];

   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == smi_pkg::ST_SINGULAR) |->
         (rsp_determinant == '0) && (rsp_r00 == '0) && (rsp_r11 == '0) && (rsp_r22 == '0))
      else $error("singular result carries nonzero data");

   a_lat_hit: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##LAT rsp_valid)
      else $error("accepted matrix gave no result strobe");

   a_lat_none: assert property (@(posedge clock) disable iff (reset)
      !start |-> ##LAT !rsp_valid)
      else $error("result strobe without an accepted matrix");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result strobe right after reset");

endmodule
